[src/mfc_pkg.sv]
// mfc_pkg: shared constants, command and status types for the MIDI file carver.
// No dependencies.
package mfc_pkg;

	localparam int FILE_HDR_LEN  = 14;
	localparam int TRK_HDR_LEN   = 8;
	localparam int HDR_BODY_LEN  = 6;
	localparam int WIN_IDX_W     = $clog2(FILE_HDR_LEN);
	localparam int TRK_HDR_START = FILE_HDR_LEN - TRK_HDR_LEN;

	localparam logic [7:0] CH_M  = 8'h4D;
	localparam logic [7:0] CH_T  = 8'h54;
	localparam logic [7:0] CH_LH = 8'h68;
	localparam logic [7:0] CH_LD = 8'h64;
	localparam logic [7:0] CH_LR = 8'h72;
	localparam logic [7:0] CH_LK = 8'h6B;

	typedef enum logic [1:0] {
		SRC_INPUT,
		SRC_WINDOW,
		SRC_MARKER
	} out_src_t;

	typedef struct packed {
		logic                 shift;
		logic                 clr_fill;
		logic                 load_file;
		logic                 load_trk;
		logic                 clr_tracks;
		logic                 dec_payload;
		logic                 out_load;
		out_src_t             out_src;
		logic [WIN_IDX_W-1:0] win_idx;
		logic                 first;
		logic                 last_file;
		logic                 last_run;
	} mfc_cmd_t;

	typedef struct packed {
		logic file_hit;
		logic trk_eighth;
		logic trk_hit;
		logic len_zero;
		logic hdr_tracks_zero;
		logic tracks_one;
		logic tracks_zero;
		logic pay_one;
	} mfc_status_t;

endpackage

[src/mfc_ifs.sv]
// mfc_ifs: valid/ready channel interfaces for input bytes and carved results.
// No dependencies.
interface mfc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface mfc_res_if;
	logic        valid;
	logic        ready;
	logic        out_kind;
	logic [7:0]  out_byte;
	logic [15:0] file_number;
	logic        first_of_file;
	logic        last_of_file;
	logic        last_of_run;

	modport source (output valid, output out_kind, output out_byte, output file_number,
		output first_of_file, output last_of_file, output last_of_run, input ready);
	modport sink (input valid, input out_kind, input out_byte, input file_number,
		input first_of_file, input last_of_file, input last_of_run, output ready);
endinterface

[src/mfc_datapath.sv]
// mfc_datapath: byte window, header matchers, track/payload/file counters and
// the result register. Depends on mfc_pkg.
module mfc_datapath
	import mfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  in_byte,
	input  mfc_cmd_t    cmd,
	output mfc_status_t status,
	output logic        out_kind,
	output logic [7:0]  out_byte,
	output logic [15:0] file_number,
	output logic        first_of_file,
	output logic        last_of_file,
	output logic        last_of_run
);

	logic [7:0]           win_q [FILE_HDR_LEN];
	logic [7:0]           nwin [FILE_HDR_LEN];
	logic [WIN_IDX_W-1:0] fill_q;
	logic [15:0]          tracks_q;
	logic [31:0]          payload_q;
	logic [15:0]          file_cnt_q;
	logic [15:0]          hdr_tracks;
	logic [31:0]          trk_len;
	logic [7:0]           sel_byte;

	always_comb begin
		for (int i = 0; i < FILE_HDR_LEN - 1; i++) begin
			nwin[i] = win_q[i+1];
		end
		nwin[FILE_HDR_LEN-1] = in_byte;
	end

	assign hdr_tracks = {nwin[10], nwin[11]};
	assign trk_len    = {nwin[10], nwin[11], nwin[12], nwin[13]};

	always_comb begin
		status.file_hit = (fill_q >= WIN_IDX_W'(FILE_HDR_LEN - 1))
			&& nwin[0] == CH_M && nwin[1] == CH_T && nwin[2] == CH_LH && nwin[3] == CH_LD
			&& {nwin[4], nwin[5], nwin[6], nwin[7]} == 32'(HDR_BODY_LEN);
		status.trk_eighth      = (fill_q == WIN_IDX_W'(TRK_HDR_LEN - 1));
		status.trk_hit         = nwin[6] == CH_M && nwin[7] == CH_T
			&& nwin[8] == CH_LR && nwin[9] == CH_LK;
		status.len_zero        = (trk_len == '0);
		status.hdr_tracks_zero = (hdr_tracks == '0);
		status.tracks_one      = (tracks_q == 16'd1);
		status.tracks_zero     = (tracks_q == '0);
		status.pay_one         = (payload_q == 32'd1);
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			for (int i = 0; i < FILE_HDR_LEN; i++) begin
				win_q[i] <= nwin[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			tracks_q   <= '0;
			payload_q  <= '0;
			file_cnt_q <= '0;
		end else begin
			if (cmd.clr_fill) begin
				fill_q <= '0;
			end else if (cmd.shift && fill_q != WIN_IDX_W'(FILE_HDR_LEN)) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.load_file) begin
				tracks_q <= hdr_tracks;
				if (file_cnt_q != 16'hFFFF) begin
					file_cnt_q <= file_cnt_q + 1'b1;
				end
			end else if (cmd.load_trk) begin
				tracks_q <= tracks_q - 1'b1;
			end else if (cmd.clr_tracks) begin
				tracks_q <= '0;
			end
			if (cmd.load_trk) begin
				payload_q <= trk_len;
			end else if (cmd.dec_payload) begin
				payload_q <= payload_q - 1'b1;
			end
		end
	end

	always_comb begin
		case (cmd.out_src)
			SRC_INPUT:  sel_byte = in_byte;
			SRC_WINDOW: sel_byte = win_q[cmd.win_idx];
			default:    sel_byte = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_kind      <= (cmd.out_src == SRC_MARKER);
			out_byte      <= sel_byte;
			file_number   <= file_cnt_q;
			first_of_file <= cmd.first;
			last_of_file  <= cmd.last_file;
			last_of_run   <= cmd.last_run;
		end
	end

endmodule

[src/mfc_ctrl.sv]
// mfc_ctrl: parse-mode state machine, header burst sequencing and handshakes.
// Depends on mfc_pkg.
module mfc_ctrl
	import mfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  mfc_status_t status,
	output mfc_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_SCAN,
		S_TRK,
		S_PAY,
		S_BURST
	} state_t;

	localparam logic [WIN_IDX_W-1:0] IDX_LAST = WIN_IDX_W'(FILE_HDR_LEN - 1);

	state_t               state_q, state_d, ret_q, ret_d;
	logic [WIN_IDX_W-1:0] idx_q, idx_d;
	logic                 last_q, last_d;
	logic                 ov_q;
	logic                 out_free;
	logic                 acc;

	assign out_free  = !ov_q || out_ready;
	assign in_ready  = (state_q != S_BURST) && out_free;
	assign acc       = in_valid && in_ready;
	assign out_valid = ov_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		ret_d   = ret_q;
		idx_d   = idx_q;
		last_d  = last_q;
		unique case (state_q)
			S_SCAN: begin
				if (acc) begin
					cmd.shift = 1'b1;
					if (status.file_hit) begin
						cmd.load_file = 1'b1;
						cmd.clr_fill  = 1'b1;
						state_d       = S_BURST;
						idx_d         = '0;
						last_d        = status.hdr_tracks_zero;
						ret_d         = status.hdr_tracks_zero ? S_SCAN : S_TRK;
					end
				end
			end
			S_TRK: begin
				if (acc) begin
					cmd.shift = 1'b1;
					if (status.trk_eighth) begin
						cmd.clr_fill = 1'b1;
						if (status.trk_hit) begin
							cmd.load_trk = 1'b1;
							state_d      = S_BURST;
							idx_d        = WIN_IDX_W'(TRK_HDR_START);
							last_d       = status.len_zero && status.tracks_one;
							if (!status.len_zero) begin
								ret_d = S_PAY;
							end else begin
								ret_d = status.tracks_one ? S_SCAN : S_TRK;
							end
						end else begin
							cmd.clr_tracks = 1'b1;
							cmd.out_load   = 1'b1;
							cmd.out_src    = SRC_MARKER;
							cmd.last_run   = 1'b1;
							state_d        = S_SCAN;
						end
					end
				end
			end
			S_PAY: begin
				if (acc) begin
					cmd.dec_payload = 1'b1;
					cmd.out_load    = 1'b1;
					cmd.out_src     = SRC_INPUT;
					cmd.last_file   = status.pay_one && status.tracks_zero;
					cmd.last_run    = 1'b1;
					if (status.pay_one) begin
						cmd.clr_fill = 1'b1;
						state_d      = status.tracks_zero ? S_SCAN : S_TRK;
					end
				end
			end
			S_BURST: begin
				if (out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_src   = SRC_WINDOW;
					cmd.win_idx   = idx_q;
					cmd.first     = (idx_q == '0);
					cmd.last_file = (idx_q == IDX_LAST) && last_q;
					cmd.last_run  = (idx_q == IDX_LAST);
					idx_d         = idx_q + 1'b1;
					if (idx_q == IDX_LAST) begin
						state_d = ret_q;
					end
				end
			end
			default: state_d = S_SCAN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SCAN;
			ret_q   <= S_SCAN;
			idx_q   <= '0;
			last_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			idx_q   <= idx_d;
			last_q  <= last_d;
			if (cmd.out_load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	a_hit_starts_burst: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && acc && status.file_hit |=> state_q == S_BURST && idx_q == '0)
		else $error("file header match did not start a burst at byte 0");

	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BURST && idx_q == IDX_LAST && out_free |=> state_q != S_BURST)
		else $error("header burst ran past the last window byte");

	a_burst_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BURST |-> idx_q <= IDX_LAST)
		else $error("burst index out of window range");

	a_payload_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PAY && acc |=> ov_q)
		else $error("payload transfer produced no result");

endmodule

[src/midi_file_carver.sv]
// midi_file_carver: carves Standard MIDI Files out of a byte stream.
// Scanning and payload bytes: one transfer per cycle while the result register is free; a
// payload byte's result is valid in the cycle after its transfer. A header match holds input
// while its 14 (file) or 8 (track) header results go out one per cycle, whenever the single
// result register is free, from the burst state. Reset (arst_n, async, active low) clears mode, counters
// and result valid; window and result data are not reset. Depends on mfc_pkg, mfc_ifs.
module midi_file_carver
	import mfc_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	mfc_byte_if.sink  blob,
	mfc_res_if.source carved
);

	mfc_cmd_t    cmd;
	mfc_status_t status;

	mfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (blob.valid),
		.in_ready  (blob.ready),
		.out_valid (carved.valid),
		.out_ready (carved.ready),
		.status    (status),
		.cmd       (cmd)
	);

	mfc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_byte       (blob.in_byte),
		.cmd           (cmd),
		.status        (status),
		.out_kind      (carved.out_kind),
		.out_byte      (carved.out_byte),
		.file_number   (carved.file_number),
		.first_of_file (carved.first_of_file),
		.last_of_file  (carved.last_of_file),
		.last_of_run   (carved.last_of_run)
	);

endmodule

[sim/mfc_carve_checker.sv]
// mfc_carve_checker: watches the byte and result channels of the MIDI file carver,
// predicts every carved result and compares it field by field.
// Depends on mfc_pkg.
`timescale 1ns / 1ps

module mfc_carve_checker
	import mfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic        res_kind,
	input  logic [7:0]  res_byte,
	input  logic [15:0] res_file,
	input  logic        res_first,
	input  logic        res_lastf,
	input  logic        res_lastr,
	output int unsigned failures,
	output int unsigned pending
);

	typedef enum logic [1:0] {
		CARVE_SCAN,
		CARVE_TRK_HDR,
		CARVE_PAYLOAD
	} carve_mode_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [15:0] fnum;
		logic        first;
		logic        lastf;
		logic        lastr;
	} carved_t;

	carved_t     carved_q[$];
	logic [7:0]  win [FILE_HDR_LEN];
	int          fill;
	carve_mode_t mode;
	logic [15:0] tracks_left;
	logic [31:0] payload_left;
	logic [15:0] file_cnt;
	int unsigned res_idx;

	function automatic void push_result(logic kind, logic [7:0] data, logic first,
		logic lastf);
		carved_q.push_back(carved_t'{kind, data, file_cnt, first, lastf, 1'b0});
	endfunction

	function automatic void carve_byte(logic [7:0] b);
		int          n_before;
		logic [31:0] len;
		carved_t     tail;
		n_before = carved_q.size();
		case (mode)
			CARVE_PAYLOAD: begin
				payload_left = payload_left - 32'd1;
				push_result(1'b0, b, 1'b0, payload_left == 0 && tracks_left == 0);
				if (payload_left == 0) begin
					mode = (tracks_left == 0) ? CARVE_SCAN : CARVE_TRK_HDR;
					fill = 0;
				end
			end
			CARVE_TRK_HDR: begin
				if (fill >= TRK_HDR_LEN)
					fill = 0;
				win[fill] = b;
				fill++;
				if (fill == TRK_HDR_LEN) begin
					fill = 0;
					if (win[0] == CH_M && win[1] == CH_T && win[2] == CH_LR && win[3] == CH_LK) begin
						len = {win[4], win[5], win[6], win[7]};
						tracks_left = tracks_left - 16'd1;
						for (int i = 0; i < TRK_HDR_LEN; i++)
							push_result(1'b0, win[i], 1'b0,
								i == TRK_HDR_LEN - 1 && len == 0 && tracks_left == 0);
						payload_left = len;
						if (len != 0)
							mode = CARVE_PAYLOAD;
						else if (tracks_left == 0)
							mode = CARVE_SCAN;
					end else begin
						push_result(1'b1, 8'h00, 1'b0, 1'b0);
						tracks_left = 0;
						mode = CARVE_SCAN;
					end
				end
			end
			default: begin
				mode = CARVE_SCAN;
				if (fill < FILE_HDR_LEN) begin
					win[fill] = b;
					fill++;
				end else begin
					for (int i = 0; i < FILE_HDR_LEN - 1; i++)
						win[i] = win[i + 1];
					win[FILE_HDR_LEN - 1] = b;
				end
				if (fill == FILE_HDR_LEN && win[0] == CH_M && win[1] == CH_T &&
					win[2] == CH_LH && win[3] == CH_LD &&
					{win[4], win[5], win[6], win[7]} == HDR_BODY_LEN) begin
					if (file_cnt != 16'hFFFF)
						file_cnt = file_cnt + 16'd1;
					tracks_left = {win[10], win[11]};
					for (int i = 0; i < FILE_HDR_LEN; i++)
						push_result(1'b0, win[i], i == 0,
							i == FILE_HDR_LEN - 1 && tracks_left == 0);
					fill = 0;
					if (tracks_left != 0)
						mode = CARVE_TRK_HDR;
				end
			end
		endcase
		if (carved_q.size() > n_before) begin
			tail = carved_q.pop_back();
			tail.lastr = 1'b1;
			carved_q.push_back(tail);
		end
	endfunction

	function automatic void check_result();
		carved_t got;
		carved_t exp_r;
		got = '{res_kind, res_byte, res_file, res_first, res_lastf, res_lastr};
		if (carved_q.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("%0t: unexpected result kind=%0d byte=%02h file=%0d", $realtime,
					got.kind, got.data, got.fnum);
		end else begin
			exp_r = carved_q.pop_front();
			if (got !== exp_r) begin
				failures++;
				if (failures <= 10)
					$display({"%0t: result %0d: expected kind=%0d byte=%02h file=%0d ",
						"first=%0d lastf=%0d lastr=%0d, got kind=%0d byte=%02h file=%0d ",
						"first=%0d lastf=%0d lastr=%0d"}, $realtime, res_idx,
						exp_r.kind, exp_r.data, exp_r.fnum, exp_r.first, exp_r.lastf,
						exp_r.lastr, got.kind, got.data, got.fnum, got.first, got.lastf,
						got.lastr);
			end
		end
		res_idx++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carved_q.delete();
			fill = 0;
			mode = CARVE_SCAN;
			tracks_left = '0;
			payload_left = '0;
			file_cnt = '0;
			res_idx = 0;
			failures = 0;
			pending = 0;
		end else begin
			if (in_valid && in_ready)
				carve_byte(in_byte);
			if (res_valid && res_ready)
				check_result();
			pending = carved_q.size();
		end
	end

endmodule

[sim/tb_midi_file_carver.sv]
// tb_midi_file_carver: drives byte streams with embedded MIDI files into the carver,
// idles both channels at random and reports the checker's verdict.
// Depends on mfc_pkg, mfc_ifs, midi_file_carver, mfc_carve_checker.
`timescale 1ns / 1ps

module tb_midi_file_carver;
	import mfc_pkg::*;

	logic clk;
	logic arst_n;

	mfc_byte_if blob();
	mfc_res_if  carved();

	int unsigned failures;
	int unsigned pending;

	int sent;
	bit tx_free;
	bit rx_free;
	bit squeeze;
	bit hold_done;
	int rx_idle;
	int rx_run;

	midi_file_carver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.blob   (blob),
		.carved (carved)
	);

	mfc_carve_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (blob.valid),
		.in_ready  (blob.ready),
		.in_byte   (blob.in_byte),
		.res_valid (carved.valid),
		.res_ready (carved.ready),
		.res_kind  (carved.out_kind),
		.res_byte  (carved.out_byte),
		.res_file  (carved.file_number),
		.res_first (carved.first_of_file),
		.res_lastf (carved.last_of_file),
		.res_lastr (carved.last_of_run),
		.failures  (failures),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("midi_file_carver: mismatch");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 30);
	endfunction

	task automatic put(input logic [7:0] b);
		int gap;
		@(negedge clk);
		blob.valid <= 1'b1;
		blob.in_byte <= b;
		@(posedge clk);
		while (!blob.ready)
			@(posedge clk);
		sent++;
		gap = tx_free ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			blob.valid <= 1'b0;
			blob.in_byte <= 8'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic put_word(input logic [31:0] w);
		put(w[31:24]);
		put(w[23:16]);
		put(w[15:8]);
		put(w[7:0]);
	endtask

	task automatic put_file_hdr(input logic [15:0] ntrk);
		put(CH_M);
		put(CH_T);
		put(CH_LH);
		put(CH_LD);
		put_word(HDR_BODY_LEN);
		put(8'($urandom));
		put(8'($urandom));
		put(ntrk[15:8]);
		put(ntrk[7:0]);
		put(8'($urandom));
		put(8'($urandom));
	endtask

	task automatic put_track(input logic [31:0] len, input int n_pay);
		put(CH_M);
		put(CH_T);
		put(CH_LR);
		put(CH_LK);
		put_word(len);
		repeat (n_pay) put(8'($urandom));
	endtask

	// one of the four tag bytes is corrupted
	task automatic put_bad_track();
		logic [7:0] tag [4];
		logic [7:0] b;
		int k;
		tag = '{CH_M, CH_T, CH_LR, CH_LK};
		k = $urandom_range(0, 3);
		for (int i = 0; i < 4; i++) begin
			b = tag[i];
			if (i == k)
				while (b == tag[i])
					b = 8'($urandom);
			put(b);
		end
		put_word($urandom);
	endtask

	// result side
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (squeeze && !hold_done) begin
				hold_done = 1'b1;
				carved.ready <= 1'b0;
				repeat (300) @(negedge clk);
				carved.ready <= 1'b1;
			end else if (rx_free || rx_run > 0) begin
				carved.ready <= 1'b1;
				if (rx_run > 0)
					rx_run--;
			end else if (rx_idle > 0) begin
				carved.ready <= 1'b0;
				rx_idle--;
			end else begin
				carved.ready <= 1'b1;
				rx_idle = pick_gap();
				if ($urandom_range(0, 9) == 0)
					rx_run = $urandom_range(20, 60);
			end
		end
	end

	initial begin
		int          start;
		logic [15:0] ntrk;
		logic [31:0] len;
		arst_n = 1'b0;
		blob.valid = 1'b0;
		blob.in_byte = 8'h00;
		carved.ready = 1'b0;
		sent = 0;
		tx_free = 1'b0;
		rx_free = 1'b0;
		squeeze = 1'b0;
		hold_done = 1'b0;
		rx_idle = 0;
		rx_run = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed: partial window, near-miss header, zero tracks, zero-length tracks,
		// bad track header, all-ones track count
		put(8'h00);
		put(8'hFF);
		put(CH_M);
		put(CH_M);
		put(CH_T);
		put(CH_LH);
		put(CH_LD);
		put_word(32'd7);
		put_file_hdr(16'd0);
		put_file_hdr(16'd2);
		put_track(32'd0, 0);
		put_bad_track();
		put_file_hdr(16'd1);
		put_track(32'd0, 0);
		put_file_hdr(16'd2);
		put_track(32'd1, 1);
		put_track(32'd3, 3);
		put_file_hdr(16'hFFFF);
		put_track(32'd2, 2);
		put_bad_track();

		// random: mostly well-formed files, some noise and broken headers
		squeeze = 1'b1;
		start = sent;
		while (sent - start < 40) begin
			tx_free = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: repeat ($urandom_range(1, 6)) put(8'($urandom));
				1: begin
					put(CH_M);
					put(CH_T);
					put(CH_LH);
					put(CH_LD);
					put_word(32'(HDR_BODY_LEN) ^ (32'd1 << $urandom_range(0, 31)));
					repeat (6) put(8'($urandom));
				end
				2: begin
					put_file_hdr(16'($urandom));
					put_bad_track();
				end
				default: begin
					if ($urandom_range(0, 9) == 0)
						ntrk = 16'($urandom_range(4, 65535));
					else
						ntrk = 16'($urandom_range(0, 3));
					put_file_hdr(ntrk);
					for (int i = 0; i < ntrk; i++) begin
						if (i >= 3 || $urandom_range(0, 9) == 0) begin
							put_bad_track();
							break;
						end
						len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 40)
							: $urandom_range(0, 5);
						put_track(len, len);
					end
				end
			endcase
		end

		// stream ends inside a huge track
		tx_free = 1'b0;
		rx_free = 1'b0;
		put_file_hdr(16'd1);
		put_track(32'hFFFF_FFFF, 4);
		@(negedge clk);
		blob.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("midi_file_carver: match");
		else
			$display("midi_file_carver: mismatch");
		$finish;
	end

endmodule
